>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define SSTRK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked through reset as well.
`define SSTRK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sstrk_pkg.sv
// Shared types and constants of the shunt sensor frame tracker.
package sstrk_pkg;

   localparam int unsigned ID_W        = 11;
   localparam int unsigned PAYLOAD_W   = 32;
   localparam int unsigned SEL_W       = 5;
   localparam int unsigned VOLT_W      = 34;
   localparam int unsigned VALUE_W     = 35;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 31;
   localparam int unsigned DIV10_SHIFT = 35;

   typedef logic [ID_W-1:0]               frame_id_type;
   typedef logic signed [PAYLOAD_W-1:0]   payload_type;
   typedef logic [SEL_W-1:0]              read_select_type;
   typedef logic signed [VOLT_W-1:0]      volt_type;
   typedef logic signed [VALUE_W-1:0]     value_type;
   typedef logic [COUNT_W-1:0]            count_type;
   typedef logic [CSR_INDEX_W-1:0]        csr_index_type;
   typedef logic [CSR_DATA_W-1:0]         csr_data_type;

   // Opcodes
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Frame identifiers
   localparam frame_id_type ID_FIRST   = 11'h510;
   localparam frame_id_type ID_LAST    = 11'h528;
   localparam frame_id_type ID_CURRENT = 11'h521;
   localparam frame_id_type ID_VOLT    = 11'h522;
   localparam frame_id_type ID_VOLT2   = 11'h523;
   localparam frame_id_type ID_VOLT3   = 11'h524;
   localparam frame_id_type ID_TEMP    = 11'h525;
   localparam frame_id_type ID_POWER   = 11'h526;
   localparam frame_id_type ID_CHARGE  = 11'h527;
   localparam frame_id_type ID_ENERGY  = 11'h528;

   // Register indexes
   localparam csr_index_type CSR_WARMUP       = 2'd0;
   localparam csr_index_type CSR_V2_THRESHOLD = 2'd1;
   localparam csr_index_type CSR_V3_FLOOR     = 2'd2;

   localparam count_type    WARMUP_RESET       = 8'd150;
   localparam csr_data_type V2_THRESHOLD_RESET = 31'd3000;
   localparam csr_data_type V3_FLOOR_RESET     = 31'd10000;
   localparam count_type    COUNT_MAX          = 8'd255;

   // Voltage slots
   localparam logic [1:0] VIDX_MAIN = 2'd0;
   localparam logic [1:0] VIDX_V1   = 2'd1;
   localparam logic [1:0] VIDX_V2   = 2'd2;
   localparam logic [1:0] VIDX_V3   = 2'd3;

   // Read selects
   localparam read_select_type SEL_CURRENT = 5'd0;
   localparam read_select_type SEL_VOLT    = 5'd1;
   localparam read_select_type SEL_VOLT1   = 5'd2;
   localparam read_select_type SEL_VOLT2   = 5'd3;
   localparam read_select_type SEL_VOLT3   = 5'd4;
   localparam read_select_type SEL_VOLT_LO  = 5'd5;
   localparam read_select_type SEL_VOLT_HI  = 5'd6;
   localparam read_select_type SEL_VOLT1_LO = 5'd7;
   localparam read_select_type SEL_VOLT1_HI = 5'd8;
   localparam read_select_type SEL_VOLT2_LO = 5'd9;
   localparam read_select_type SEL_VOLT2_HI = 5'd10;
   localparam read_select_type SEL_VOLT3_LO = 5'd11;
   localparam read_select_type SEL_VOLT3_HI = 5'd12;
   localparam read_select_type SEL_TEMP    = 5'd13;
   localparam read_select_type SEL_POWER   = 5'd14;
   localparam read_select_type SEL_CHARGE  = 5'd15;
   localparam read_select_type SEL_ENERGY  = 5'd16;
   localparam read_select_type SEL_COUNT   = 5'd17;

   // x/10 for x < 2**32: (x * ceil(2**35/10)) >> 35
   localparam logic [PAYLOAD_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;

endpackage

>>> rtl/core/sstrk_req_if.sv
// Request channel interface: frames and read requests.
interface sstrk_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   sstrk_pkg::frame_id_type    frame_id;
   sstrk_pkg::payload_type     frame_payload;
   sstrk_pkg::read_select_type read_select;

   modport source (output valid, opcode, frame_id, frame_payload, read_select, input ready);
   modport sink   (input valid, opcode, frame_id, frame_payload, read_select, output ready);
endinterface

>>> rtl/core/sstrk_rsp_if.sv
// Response channel interface: read values.
interface sstrk_rsp_if;
   logic                 valid;
   logic                 ready;
   sstrk_pkg::value_type read_value;

   modport source (output valid, read_value, input ready);
   modport sink   (input valid, read_value, output ready);
endinterface

>>> rtl/core/shunt_sensor_frame_tracker.sv
// Shunt sensor frame tracker: measurement state, marks, accumulators and reads.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+-------------------------------------------
//   req_ch  | in  | valid/ready       | opcode, frame_id, frame_payload, read_select
//   rsp_ch  | out | valid/ready       | read_value
//   csr_*   | in  | csr_write_enable  | csr_index, csr_write_data
//
// One transaction per cycle while req_ch.ready is high. A frame updates state at the edge
// it is accepted; a read samples state at its accepting edge and its value is registered
// into the output register, or into the skid entry while the output register holds an
// unread value. The rate is set by the output register plus one skid entry: req_ch.ready
// drops only while both hold an unread value, and during reset. Reset is synchronous.
module shunt_sensor_frame_tracker (
   input  logic                      clock,
   input  logic                      reset,
   sstrk_req_if.sink                 req_ch,
   sstrk_rsp_if.source               rsp_ch,
   input  logic                      csr_write_enable,
   input  sstrk_pkg::csr_index_type  csr_index,
   input  sstrk_pkg::csr_data_type   csr_write_data
);

   sstrk_pkg::count_type    warmup_ff;
   sstrk_pkg::csr_data_type v2_thr_ff;
   sstrk_pkg::csr_data_type v3_floor_ff;

   sstrk_pkg::payload_type  current_ff,  current_in;
   sstrk_pkg::volt_type     volt_ff [4];
   sstrk_pkg::volt_type     volt_in [4];
   sstrk_pkg::volt_type     marks_ff [8];
   sstrk_pkg::volt_type     marks_in [8];
   sstrk_pkg::payload_type  temp_ff,     temp_in;
   sstrk_pkg::payload_type  power_ff,    power_in;
   sstrk_pkg::volt_type     charge_ff,   charge_in;
   sstrk_pkg::payload_type  last_chg_ff, last_chg_in;
   sstrk_pkg::volt_type     energy_ff,   energy_in;
   sstrk_pkg::payload_type  last_nrg_ff, last_nrg_in;
   sstrk_pkg::count_type    count_ff,    count_in;

   logic                    out_valid_ff,  out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   sstrk_pkg::value_type    out_value_ff,  out_value_in;
   sstrk_pkg::value_type    skid_value_ff, skid_value_in;

   logic                    take;
   logic                    frame_take;
   logic                    read_take;
   logic                    pop;
   logic                    warm;
   logic [3:0]              vupd;
   sstrk_pkg::payload_type  p;
   sstrk_pkg::volt_type     p34;
   logic signed [32:0]      p33;
   logic signed [32:0]      v2_adj;
   logic signed [34:0]      v1_wide;
   sstrk_pkg::volt_type     v2_new;
   sstrk_pkg::volt_type     floor34;
   logic [31:0]             mag;
   logic [63:0]             prod;
   logic [31:0]             quot;
   sstrk_pkg::value_type    read_value;

   assign req_ch.ready = ~skid_valid_ff & ~reset;
   assign take         = req_ch.valid & req_ch.ready;
   assign read_take    = take & (req_ch.opcode == sstrk_pkg::OP_READ);
   assign frame_take   = take & (req_ch.opcode == sstrk_pkg::OP_FRAME)
                         & (req_ch.frame_id >= sstrk_pkg::ID_FIRST)
                         & (req_ch.frame_id <= sstrk_pkg::ID_LAST);
   assign pop          = out_valid_ff & rsp_ch.ready;

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.read_value = out_value_ff;

   assign p       = req_ch.frame_payload;
   assign p34     = sstrk_pkg::volt_type'(p);
   assign p33     = 33'(p);
   assign floor34 = sstrk_pkg::volt_type'({3'b000, v3_floor_ff});

   // Counter and warm-up
   assign count_in = (frame_take && count_ff != sstrk_pkg::COUNT_MAX) ?
                     count_ff + 8'd1 : count_ff;
   assign warm     = count_in < warmup_ff;

   // Derived voltages
   assign v2_adj  = (p33 > $signed({2'b00, v2_thr_ff})) ?
                    p33 - 33'(volt_ff[sstrk_pkg::VIDX_V3]) : p33;
   assign v2_new  = sstrk_pkg::volt_type'(v2_adj);
   assign v1_wide = 35'(p) - (35'(volt_ff[sstrk_pkg::VIDX_V2])
                              + 35'(volt_ff[sstrk_pkg::VIDX_V3]));

   // Temperature: truncating divide by ten on the magnitude
   assign mag  = p[31] ? (~p + 32'd1) : p;
   assign prod = 64'(mag) * 64'(sstrk_pkg::DIV10_RECIP);
   assign quot = 32'(prod >> sstrk_pkg::DIV10_SHIFT);

   always_comb begin
      current_in  = current_ff;
      temp_in     = temp_ff;
      power_in    = power_ff;
      charge_in   = charge_ff;
      last_chg_in = last_chg_ff;
      energy_in   = energy_ff;
      last_nrg_in = last_nrg_ff;
      volt_in     = volt_ff;
      vupd        = '0;
      if (frame_take) begin
         unique case (req_ch.frame_id)
            sstrk_pkg::ID_CURRENT: begin
               current_in = p;
            end
            sstrk_pkg::ID_VOLT: begin
               volt_in[sstrk_pkg::VIDX_MAIN] = p34;
               volt_in[sstrk_pkg::VIDX_V1]   = v1_wide[33:0];
               vupd[sstrk_pkg::VIDX_MAIN]    = 1'b1;
               vupd[sstrk_pkg::VIDX_V1]      = 1'b1;
            end
            sstrk_pkg::ID_VOLT2: begin
               volt_in[sstrk_pkg::VIDX_V2] = v2_new;
               vupd[sstrk_pkg::VIDX_V2]    = 1'b1;
            end
            sstrk_pkg::ID_VOLT3: begin
               volt_in[sstrk_pkg::VIDX_V3] = p34;
               vupd[sstrk_pkg::VIDX_V3]    = 1'b1;
            end
            sstrk_pkg::ID_TEMP: begin
               temp_in = p[31] ? (32'd0 - quot) : quot;
            end
            sstrk_pkg::ID_POWER: begin
               power_in = p;
            end
            sstrk_pkg::ID_CHARGE: begin
               charge_in   = charge_ff + (p34 - sstrk_pkg::volt_type'(last_chg_ff));
               last_chg_in = p;
            end
            sstrk_pkg::ID_ENERGY: begin
               energy_in   = energy_ff + (p34 - sstrk_pkg::volt_type'(last_nrg_ff));
               last_nrg_in = p;
            end
            default: begin
            end
         endcase
      end
   end

   // Low/high marks per voltage
   always_comb begin
      marks_in = marks_ff;
      for (int k = 0; k < 4; k++) begin
         if (vupd[k]) begin
            if (warm) begin
               marks_in[2*k] = volt_in[k];
            end else begin
               if (volt_in[k] < marks_ff[2*k] && (k != 3 || volt_in[k] > floor34)) begin
                  marks_in[2*k] = volt_in[k];
               end
               if (volt_in[k] > marks_ff[2*k+1]) begin
                  marks_in[2*k+1] = volt_in[k];
               end
            end
         end
      end
   end

   // Read mux
   always_comb begin
      unique case (req_ch.read_select)
         sstrk_pkg::SEL_CURRENT:  read_value = 35'(current_ff);
         sstrk_pkg::SEL_VOLT:     read_value = 35'(volt_ff[0]);
         sstrk_pkg::SEL_VOLT1:    read_value = 35'(volt_ff[1]);
         sstrk_pkg::SEL_VOLT2:    read_value = 35'(volt_ff[2]);
         sstrk_pkg::SEL_VOLT3:    read_value = 35'(volt_ff[3]);
         sstrk_pkg::SEL_VOLT_LO:  read_value = 35'(marks_ff[0]);
         sstrk_pkg::SEL_VOLT_HI:  read_value = 35'(marks_ff[1]);
         sstrk_pkg::SEL_VOLT1_LO: read_value = 35'(marks_ff[2]);
         sstrk_pkg::SEL_VOLT1_HI: read_value = 35'(marks_ff[3]);
         sstrk_pkg::SEL_VOLT2_LO: read_value = 35'(marks_ff[4]);
         sstrk_pkg::SEL_VOLT2_HI: read_value = 35'(marks_ff[5]);
         sstrk_pkg::SEL_VOLT3_LO: read_value = 35'(marks_ff[6]);
         sstrk_pkg::SEL_VOLT3_HI: read_value = 35'(marks_ff[7]);
         sstrk_pkg::SEL_TEMP:     read_value = 35'(temp_ff);
         sstrk_pkg::SEL_POWER:    read_value = 35'(power_ff);
         sstrk_pkg::SEL_CHARGE:   read_value = 35'(charge_ff);
         sstrk_pkg::SEL_ENERGY:   read_value = 35'(energy_ff);
         sstrk_pkg::SEL_COUNT:    read_value = $signed({27'd0, count_ff});
         default:                 read_value = '0;
      endcase
   end

   // Output register and skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_value_in  = out_value_ff;
      skid_value_in = skid_value_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_value_in  = skid_value_ff;
            skid_valid_in = 1'b0;
         end
      end else if (read_take) begin
         if (!out_valid_ff || pop) begin
            out_value_in = read_value;
            out_valid_in = 1'b1;
         end else begin
            skid_value_in = read_value;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff     <= sstrk_pkg::WARMUP_RESET;
         v2_thr_ff     <= sstrk_pkg::V2_THRESHOLD_RESET;
         v3_floor_ff   <= sstrk_pkg::V3_FLOOR_RESET;
         current_ff    <= '0;
         volt_ff       <= '{default: '0};
         marks_ff      <= '{default: '0};
         temp_ff       <= '0;
         power_ff      <= '0;
         charge_ff     <= '0;
         last_chg_ff   <= '0;
         energy_ff     <= '0;
         last_nrg_ff   <= '0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               sstrk_pkg::CSR_WARMUP:       warmup_ff   <= csr_write_data[7:0];
               sstrk_pkg::CSR_V2_THRESHOLD: v2_thr_ff   <= csr_write_data;
               sstrk_pkg::CSR_V3_FLOOR:     v3_floor_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         current_ff    <= current_in;
         volt_ff       <= volt_in;
         marks_ff      <= marks_in;
         temp_ff       <= temp_in;
         power_ff      <= power_in;
         charge_ff     <= charge_in;
         last_chg_ff   <= last_chg_in;
         energy_ff     <= energy_in;
         last_nrg_ff   <= last_nrg_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      skid_value_ff <= skid_value_in;
   end

endmodule

>>> rtl/core/sstrk_checker.sv
// Port-level checker of the frame tracker and its bind.
`include "assert_macros.svh"

module sstrk_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_opcode,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sstrk_pkg::value_type rsp_read_value
);

   logic req_take;
   logic rsp_stall;
   logic read_free;
   logic frame_free;

   assign req_take   = req_valid & req_ready;
   assign rsp_stall  = rsp_valid & ~rsp_ready;
   assign read_free  = req_take & (req_opcode == sstrk_pkg::OP_READ) & ~rsp_valid;
   assign frame_free = req_take & (req_opcode == sstrk_pkg::OP_FRAME) & ~rsp_valid;

   `SSTRK_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "response dropped")
   `SSTRK_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_read_value), "value changed")
   `SSTRK_ASSERT(a_read_resp, clock, reset, read_free |=> rsp_valid, "read gave no response")
   `SSTRK_ASSERT(a_frame_quiet, clock, reset, frame_free |=> !rsp_valid, "frame gave a response")
   `SSTRK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "output valid after reset")

endmodule

bind shunt_sensor_frame_tracker sstrk_checker u_sstrk_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_opcode     (req_ch.opcode),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_read_value (rsp_ch.read_value)
);

>>> dv/tb_shunt_sensor_frame_tracker.sv
// Self-checking testbench for the shunt sensor frame tracker: frames, reads and settings.
module tb_shunt_sensor_frame_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import sstrk_pkg::*;

   typedef struct {
      logic            opcode;
      frame_id_type    frame_id;
      payload_type     payload;
      read_select_type read_select;
   } shunt_request_type;

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;

   sstrk_req_if req_if ();
   sstrk_rsp_if rsp_if ();

   shunt_sensor_frame_tracker dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // settings as the block holds them
   count_type    warmup_cfg;
   csr_data_type v2_thresh_cfg;
   csr_data_type v3_floor_cfg;

   // tracked measurement state
   payload_type current_now;
   volt_type    volt_now [4];
   volt_type    volt_marks [8];
   payload_type temp_now;
   payload_type power_now;
   volt_type    charge_acc;
   payload_type charge_last;
   volt_type    energy_acc;
   payload_type energy_last;
   count_type   frames_seen;

   shunt_request_type pending_reqs [$];
   value_type         read_values_due [$];
   shunt_request_type next_req;

   logic req_taken;
   logic calm;
   int   gap_left;
   int   stall_left;
   int   mismatches;
   int   n_frames;
   int   n_reads;
   int   n_settings;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_shunt_sensor_frame_tracker: done, errors");
      $finish;
   end

   function automatic void update_marks(int k, logic warm, logic floored);
      volt_type v;
      v = volt_now[k];
      if (warm) begin
         volt_marks[2*k] = v;
      end else begin
         if (v < volt_marks[2*k] && (!floored || longint'(v) > longint'(v3_floor_cfg)))
            volt_marks[2*k] = v;
         if (v > volt_marks[2*k+1])
            volt_marks[2*k+1] = v;
      end
   endfunction

   function automatic void apply_frame(frame_id_type id, payload_type p);
      longint pl;
      logic   warm;
      pl = p;
      if (id < ID_FIRST || id > ID_LAST)
         return;
      if (frames_seen != COUNT_MAX)
         frames_seen = frames_seen + 1'b1;
      warm = frames_seen < warmup_cfg;
      case (id)
         ID_CURRENT: current_now = p;
         ID_VOLT: begin
            volt_now[VIDX_MAIN] = volt_type'(pl);
            volt_now[VIDX_V1] = volt_type'(pl - (longint'(volt_now[VIDX_V2])
                                                 + longint'(volt_now[VIDX_V3])));
            update_marks(VIDX_MAIN, warm, 1'b0);
            update_marks(VIDX_V1, warm, 1'b0);
         end
         ID_VOLT2: begin
            if (pl > longint'(v2_thresh_cfg))
               volt_now[VIDX_V2] = volt_type'(pl - longint'(volt_now[VIDX_V3]));
            else
               volt_now[VIDX_V2] = volt_type'(pl);
            update_marks(VIDX_V2, warm, 1'b0);
         end
         ID_VOLT3: begin
            volt_now[VIDX_V3] = volt_type'(pl);
            update_marks(VIDX_V3, warm, 1'b1);
         end
         ID_TEMP:  temp_now = payload_type'(pl / 10);
         ID_POWER: power_now = p;
         ID_CHARGE: begin
            charge_acc = volt_type'(longint'(charge_acc) + (pl - longint'(charge_last)));
            charge_last = p;
         end
         ID_ENERGY: begin
            energy_acc = volt_type'(longint'(energy_acc) + (pl - longint'(energy_last)));
            energy_last = p;
         end
         default: ;
      endcase
   endfunction

   function automatic value_type quantity(read_select_type sel);
      longint r;
      if (sel == SEL_CURRENT)
         r = current_now;
      else if (sel >= SEL_VOLT && sel <= SEL_VOLT3)
         r = volt_now[sel - SEL_VOLT];
      else if (sel >= SEL_VOLT_LO && sel <= SEL_VOLT3_HI)
         r = volt_marks[sel - SEL_VOLT_LO];
      else if (sel == SEL_TEMP)
         r = temp_now;
      else if (sel == SEL_POWER)
         r = power_now;
      else if (sel == SEL_CHARGE)
         r = charge_acc;
      else if (sel == SEL_ENERGY)
         r = energy_acc;
      else if (sel == SEL_COUNT)
         r = frames_seen;
      else
         r = 0;
      return value_type'(r);
   endfunction

   function automatic void queue_frame(frame_id_type id, payload_type p);
      shunt_request_type t;
      t.opcode = OP_FRAME;
      t.frame_id = id;
      t.payload = p;
      t.read_select = read_select_type'($urandom);
      pending_reqs.push_back(t);
   endfunction

   function automatic void queue_read(read_select_type sel);
      shunt_request_type t;
      t.opcode = OP_READ;
      t.frame_id = frame_id_type'($urandom);
      t.payload = payload_type'($urandom);
      t.read_select = sel;
      pending_reqs.push_back(t);
   endfunction

   function automatic payload_type pick_payload();
      int unsigned m;
      m = $urandom_range(0, 99);
      if (m < 35)
         return payload_type'(int'($urandom_range(0, 40000)) - 20000);
      else if (m < 48)
         return payload_type'(longint'(v2_thresh_cfg) + longint'($urandom_range(0, 4)) - 2);
      else if (m < 60)
         return payload_type'(longint'(v3_floor_cfg) + longint'($urandom_range(0, 4)) - 2);
      else if (m < 85)
         return payload_type'($urandom);
      case ($urandom_range(0, 3))
         0: return payload_type'(32'h7FFF_FFFF);
         1: return payload_type'(32'h8000_0000);
         2: return payload_type'(0);
         default: return payload_type'(-1);
      endcase
   endfunction

   // n counts reads and frames the block acts on; ignored identifiers come on top
   function automatic void queue_random(int n);
      int unsigned    m;
      int             counted;
      frame_id_type   id;
      read_select_type sel;
      counted = 0;
      while (counted < n) begin
         m = $urandom_range(0, 99);
         if (m < 40) begin
            if ($urandom_range(0, 9) == 0)
               sel = read_select_type'($urandom_range(18, 31));
            else
               sel = read_select_type'($urandom_range(0, 17));
            queue_read(sel);
            counted++;
         end else begin
            m = $urandom_range(0, 99);
            if (m < 75)
               id = ID_CURRENT + frame_id_type'($urandom_range(0, 7));
            else if (m < 87)
               id = ID_FIRST + frame_id_type'($urandom_range(0, 16));
            else
               id = frame_id_type'($urandom);
            queue_frame(id, pick_payload());
            if (id >= ID_FIRST && id <= ID_LAST)
               counted++;
         end
      end
   endfunction

   task automatic write_setting(csr_index_type idx, csr_data_type data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      case (idx)
         CSR_WARMUP:       warmup_cfg = data[COUNT_W-1:0];
         CSR_V2_THRESHOLD: v2_thresh_cfg = data;
         CSR_V3_FLOOR:     v3_floor_cfg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic apply_settings(count_type w, csr_data_type th, csr_data_type fl);
      write_setting(CSR_WARMUP, csr_data_type'(w));
      write_setting(CSR_V2_THRESHOLD, th);
      write_setting(CSR_V3_FLOOR, fl);
      n_settings++;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_if.valid || read_values_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
         end else if (pending_reqs.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            gap_left = $urandom_range(0, 3);
         end else begin
            next_req = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.opcode <= next_req.opcode;
            req_if.frame_id <= next_req.frame_id;
            req_if.frame_payload <= next_req.payload;
            req_if.read_select <= next_req.read_select;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor: check responses, then predict for accepted requests
   always @(posedge clock) begin
      value_type want;
      req_taken <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (read_values_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected read value %0d", rsp_if.read_value);
            end else begin
               want = read_values_due.pop_front();
               if (rsp_if.read_value !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("read value mismatch: expected %0d got %0d",
                              want, rsp_if.read_value);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.opcode == OP_READ) begin
               read_values_due.push_back(quantity(req_if.read_select));
               n_reads++;
            end else begin
               apply_frame(req_if.frame_id, req_if.frame_payload);
               n_frames++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_WARMUP;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.opcode = OP_FRAME;
      req_if.frame_id = '0;
      req_if.frame_payload = '0;
      req_if.read_select = '0;
      rsp_if.ready = 1'b0;
      req_taken = 1'b0;
      calm = 1'b0;
      gap_left = 0;
      stall_left = 0;
      mismatches = 0;
      n_frames = 0;
      n_reads = 0;
      n_settings = 1;

      warmup_cfg = WARMUP_RESET;
      v2_thresh_cfg = V2_THRESHOLD_RESET;
      v3_floor_cfg = V3_FLOOR_RESET;
      current_now = '0;
      foreach (volt_now[i]) volt_now[i] = '0;
      foreach (volt_marks[i]) volt_marks[i] = '0;
      temp_now = '0;
      power_now = '0;
      charge_acc = '0;
      charge_last = '0;
      energy_acc = '0;
      energy_last = '0;
      frames_seen = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset defaults, ignored ids, extremes, threshold edge, warm-up
      queue_read(SEL_COUNT);
      queue_read(read_select_type'('1));
      queue_frame(ID_FIRST - 1'b1, payload_type'(5));
      queue_frame(ID_LAST + 1'b1, payload_type'(5));
      queue_frame(ID_FIRST, payload_type'(-1));
      queue_frame(ID_CURRENT - 1'b1, payload_type'(1));
      queue_frame(ID_CURRENT, payload_type'(32'h7FFF_FFFF));
      queue_frame(ID_VOLT3, payload_type'(32'h8000_0000));
      queue_frame(ID_VOLT2, payload_type'(3000));
      queue_frame(ID_VOLT2, payload_type'(3001));
      queue_frame(ID_VOLT, payload_type'(32'h7FFF_FFFF));
      queue_frame(ID_TEMP, payload_type'(32'h8000_0000));
      queue_frame(ID_TEMP, payload_type'(-19));
      queue_frame(ID_POWER, payload_type'(-1));
      queue_frame(ID_CHARGE, payload_type'(32'h7FFF_FFFF));
      queue_frame(ID_ENERGY, payload_type'(32'h8000_0000));
      queue_read(SEL_CURRENT);
      queue_read(SEL_VOLT1);
      queue_read(SEL_VOLT2);
      queue_read(SEL_VOLT_LO);
      queue_read(SEL_VOLT3_LO);
      queue_read(SEL_TEMP);
      queue_read(SEL_CHARGE);
      queue_read(SEL_ENERGY);
      queue_read(SEL_COUNT);
      drain();

      apply_settings(COUNT_MAX, '0, '0);
      queue_random(200);
      drain();

      apply_settings('0, '1, '1);
      queue_random(200);
      drain();

      apply_settings(count_type'($urandom), csr_data_type'($urandom_range(0, 20000)),
                     csr_data_type'($urandom_range(0, 20000)));
      queue_random(200);
      drain();

      apply_settings(WARMUP_RESET, V2_THRESHOLD_RESET, V3_FLOOR_RESET);
      queue_random(200);
      drain();

      calm = 1'b1;
      apply_settings(count_type'($urandom), csr_data_type'($urandom),
                     csr_data_type'($urandom));
      queue_random(225);
      drain();

      if (read_values_due.size() != 0)
         mismatches++;
      $display("covered %0d frames and %0d reads over %0d register settings",
               n_frames, n_reads, n_settings);
      $display("frame counter ended at %0d, %0d mismatches", frames_seen, mismatches);
      if (mismatches == 0)
         $display("tb_shunt_sensor_frame_tracker: done, clean");
      else
         $display("tb_shunt_sensor_frame_tracker: done, errors");
      $finish;
   end

endmodule
